@@ rtl/mrfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame checker package
// Frame limits, CRC-16 constants, function codes, status codes and the
// byte-wide CRC update shared by the frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int unsigned MAX_FRAME = 256;
  localparam int unsigned MIN_FRAME = 4;
  localparam int unsigned LEN_W     = $clog2(MAX_FRAME + 1);

  localparam logic [LEN_W-1:0] MAX_COUNT = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0] MIN_COUNT = LEN_W'(MIN_FRAME);

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT     = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_CRC      = 3'd3,
    ST_ADDR     = 3'd4
  } frame_status_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  // One byte through the reflected CRC-16, unrolled over its eight bits.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/modbus_rtu_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame checker
// Collects received bytes of one slave frame and reports its status at end
// of frame.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while not stalled: a received byte
// or an end of frame event raised by an external silence timer. A transaction
// is held in an input register, then updates the frame state (CRC-16 over
// all but the two trailing bytes, counters, address and function byte) in a
// single pass; the byte-wide CRC update is the longest path. An end of frame
// moves from the input register into the output register once that register
// is free, and it clears the frame state. Received bytes keep flowing while
// a result waits to be taken; only an end of frame waits for the output
// register to free up.
// slave_address may be written whenever no frame is in progress.
module modbus_rtu_frame_checker_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  frame_status,
  output logic [7:0]                  function_code,
  output logic                        function_supported,
  output logic [mrfc_pkg::LEN_W-1:0]  frame_length
);
  import mrfc_pkg::*;

  logic [7:0]       slave_address;

  logic             q_valid;
  action_t          q_action;
  logic [7:0]       q_byte;
  logic             advance;

  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [7:0]       held0;
  logic [7:0]       held0_next;
  logic [7:0]       held1;
  logic [7:0]       held1_next;
  logic [LEN_W-1:0] byte_count;
  logic [LEN_W-1:0] byte_count_next;
  logic [7:0]       address_byte;
  logic [7:0]       address_byte_next;
  logic [7:0]       function_byte;
  logic [7:0]       function_byte_next;
  logic             overflow;
  logic             overflow_next;

  frame_status_t    status;
  logic [7:0]       fc;
  logic             fc_supported;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  // A byte never needs the output register, so only an end of frame waits.
  assign advance  = (q_action == ACT_BYTE) || !out_valid || !out_stall;
  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_action <= action_t'(action);
      q_byte   <= rx_byte;
    end
  end

  always_comb begin
    crc_next           = crc;
    held0_next         = held0;
    held1_next         = held1;
    byte_count_next    = byte_count;
    address_byte_next  = address_byte;
    function_byte_next = function_byte;
    overflow_next      = overflow;
    if (q_valid && advance) begin
      unique case (q_action)
        ACT_BYTE: begin
          if (byte_count >= MAX_COUNT) begin
            overflow_next = 1'b1;
          end else begin
            if (byte_count == LEN_W'(0)) begin
              address_byte_next = q_byte;
            end
            if (byte_count == LEN_W'(1)) begin
              function_byte_next = q_byte;
            end
            if (byte_count >= LEN_W'(2)) begin
              crc_next = crc_feed(crc, held0);
            end
            held0_next      = held1;
            held1_next      = q_byte;
            byte_count_next = byte_count + LEN_W'(1);
          end
        end
        ACT_END: begin
          crc_next           = CRC_PRESET;
          held0_next         = 8'h00;
          held1_next         = 8'h00;
          byte_count_next    = '0;
          address_byte_next  = 8'h00;
          function_byte_next = 8'h00;
          overflow_next      = 1'b0;
        end
        default: begin
          overflow_next = overflow;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= CRC_PRESET;
      held0         <= 8'h00;
      held1         <= 8'h00;
      byte_count    <= '0;
      address_byte  <= 8'h00;
      function_byte <= 8'h00;
      overflow      <= 1'b0;
    end else begin
      crc           <= crc_next;
      held0         <= held0_next;
      held1         <= held1_next;
      byte_count    <= byte_count_next;
      address_byte  <= address_byte_next;
      function_byte <= function_byte_next;
      overflow      <= overflow_next;
    end
  end

  // The two held bytes are the received CRC, low byte first on the line.
  always_comb begin
    fc = (byte_count >= LEN_W'(2)) ? function_byte : 8'h00;
    fc_supported = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT) ||
                   (fc == FC_WRITE_SINGLE) || (fc == FC_WRITE_MULTIPLE);
    priority if (overflow) begin
      status = ST_OVERFLOW;
    end else if (byte_count < MIN_COUNT) begin
      status = ST_SHORT;
    end else if (crc != {held1, held0}) begin
      status = ST_CRC;
    end else if (address_byte != slave_address) begin
      status = ST_ADDR;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_valid && advance && (q_action == ACT_END)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && advance && (q_action == ACT_END)) begin
      frame_status       <= status;
      function_code      <= fc;
      function_supported <= fc_supported;
      frame_length       <= byte_count;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_COUNT)
    else $error("byte count beyond the maximum frame size");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (byte_count == MAX_COUNT))
    else $error("overflow flagged on a frame that is not full");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (q_valid && advance && (q_action == ACT_END)) |=>
      ((byte_count == '0) && (crc == CRC_PRESET) && !overflow && out_valid))
    else $error("end of frame did not clear the frame state or post a result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (q_valid && (q_action == ACT_END) && out_valid))
    else $error("input stalled without a pending end of frame");

  a_length_matches: assert property (@(posedge clk) disable iff (rst)
    (q_valid && advance && (q_action == ACT_END)) |=>
      (frame_length == $past(byte_count)))
    else $error("reported frame length differs from the byte count");

endmodule

@@ dv/modbus_rtu_frame_checker_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU frame checker testbench
// Sends slave frames built with a correct CRC, damaged copies of them, short
// frames, random noise and frames at and past the maximum size. A frame
// tracker follows every accepted byte and end of frame, and checks each
// frame report field by field. Both sides idle at random in several phases,
// and the slave address is changed between phases.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker_top_tb;
  import mrfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 8;

  typedef struct packed {
    frame_status_t     status;
    logic [7:0]        fc;
    logic              sup;
    logic [LEN_W-1:0]  len;
  } frame_report_t;

  // Bit-serial form of the reflected CRC-16.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  class frame_tracker;
    logic [7:0]       slave_addr;
    logic [15:0]      crc_acc;
    logic [7:0]       tail [2];
    int unsigned      count;
    logic [7:0]       addr_byte;
    logic [7:0]       fc_byte;
    bit               dropped;
    frame_report_t    pending_reports[$];
    int unsigned      mismatch_count;

    function new();
      slave_addr     = 8'd1;
      mismatch_count = 0;
      restart();
    endfunction

    function void restart();
      crc_acc   = CRC_PRESET;
      tail[0]   = 8'h00;
      tail[1]   = 8'h00;
      count     = 0;
      addr_byte = 8'h00;
      fc_byte   = 8'h00;
      dropped   = 1'b0;
    endfunction

    function void note_item(input action_t act, input logic [7:0] b);
      frame_report_t r;
      if (act == ACT_BYTE) begin
        if (count >= MAX_FRAME) begin
          dropped = 1'b1;
        end else begin
          if (count == 0) begin
            addr_byte = b;
          end else if (count == 1) begin
            fc_byte = b;
          end
          // The CRC runs two bytes behind, so the trailing CRC stays out.
          if (count >= 2) begin
            crc_acc = crc16_update(crc_acc, tail[0]);
          end
          tail[0] = tail[1];
          tail[1] = b;
          count++;
        end
      end else begin
        r.fc  = (count >= 2) ? fc_byte : 8'h00;
        r.sup = r.fc inside {FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_SINGLE,
                             FC_WRITE_MULTIPLE};
        r.len = LEN_W'(count);
        if (dropped) begin
          r.status = ST_OVERFLOW;
        end else if (count < MIN_FRAME) begin
          r.status = ST_SHORT;
        end else if (crc_acc != {tail[1], tail[0]}) begin
          r.status = ST_CRC;
        end else if (addr_byte != slave_addr) begin
          r.status = ST_ADDR;
        end else begin
          r.status = ST_OK;
        end
        pending_reports.push_back(r);
        restart();
      end
    endfunction

    function void flag(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_frame_report(input logic [2:0] st, input logic [7:0] fc,
                                     input logic sup, input logic [LEN_W-1:0] len);
      frame_report_t e;
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected frame report: status %0d fc %02h sup %0d len %0d",
                       st, fc, sup, len));
      end else begin
        e = pending_reports.pop_front();
        if (st !== e.status || fc !== e.fc || sup !== e.sup || len !== e.len) begin
          flag($sformatf({"frame report mismatch: expected status %0d fc %02h sup %0d",
                          " len %0d, got status %0d fc %02h sup %0d len %0d"},
                         e.status, e.fc, e.sup, e.len, st, fc, sup, len));
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              action;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        frame_status;
  logic [7:0]        function_code;
  logic              function_supported;
  logic [LEN_W-1:0]  frame_length;

  frame_tracker      tracker;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  bit                hold_req = 1'b0;
  int unsigned       items_sent = 0;
  int unsigned       cycles = 0;

  modbus_rtu_frame_checker_top dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .frame_status       (frame_status),
    .function_code      (function_code),
    .function_supported (function_supported),
    .frame_length       (frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && tracker != null) begin
      if (in_valid && !in_stall) begin
        tracker.note_item(action_t'(action), rx_byte);
      end
      if (out_valid && !out_stall) begin
        tracker.check_frame_report(frame_status, function_code, function_supported,
                                   frame_length);
      end
    end
  end

  task automatic send_item(input action_t act, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] body[$]);
    foreach (body[i]) begin
      send_item(ACT_BYTE, body[i]);
    end
    send_item(ACT_END, 8'($urandom));
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc, input int n_data,
                            input bit corrupt);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          pos;
    body.push_back(addr);
    body.push_back(fc);
    repeat (n_data) body.push_back(8'($urandom));
    crc = CRC_PRESET;
    foreach (body[i]) begin
      crc = crc16_update(crc, body[i]);
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (corrupt) begin
      pos       = $urandom_range(body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(7));
    end
    send_bytes(body);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] body[$];
    repeat (n) body.push_back(8'($urandom));
    send_bytes(body);
  endtask

  function automatic logic [7:0] pick_fc();
    case ($urandom_range(9))
      0, 1:    return FC_READ_HOLDING;
      2, 3:    return FC_READ_INPUT;
      4, 5:    return FC_WRITE_SINGLE;
      6:       return FC_WRITE_MULTIPLE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_frames(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  addr;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      addr = ($urandom_range(9) == 0) ? 8'($urandom) : tracker.slave_addr;
      if (pick < 62) begin
        send_frame(addr, pick_fc(), $urandom_range(8), 1'b0);
      end else if (pick < 77) begin
        send_frame(addr, pick_fc(), $urandom_range(8), 1'b1);
      end else if (pick < 88) begin
        send_noise($urandom_range(3));
      end else begin
        send_noise($urandom_range(16));
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.slave_addr = value;
  endtask

  initial begin
    tracker = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_BYTE;
    rx_byte   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data  <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames against the reset address.
    send_noise(0);
    send_bytes('{8'hFF});
    send_bytes('{8'h00, 8'h00, 8'hFF});
    send_frame(8'h01, FC_READ_HOLDING, 0, 1'b0);
    send_frame(8'h01, FC_WRITE_SINGLE, 0, 1'b0);
    send_frame(8'h01, FC_WRITE_MULTIPLE, 0, 1'b0);
    send_frame(8'h01, FC_READ_INPUT, 0, 1'b1);
    send_frame(8'hFE, 8'hFF, 0, 1'b0);
    settle();

    // No idling; includes a frame of exactly the maximum size.
    write_address(8'h00);
    random_frames(40);
    send_frame(8'h00, FC_READ_INPUT, MAX_FRAME - 4, 1'b0);
    random_frames(10);
    settle();

    write_address(8'hFF);
    send_idle_pct = 78;
    random_frames(60);
    settle();

    write_address(8'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 78;
    random_frames(60);
    settle();

    // Both sides idle; includes a frame that runs past the maximum size.
    write_address(8'h01);
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    random_frames(30);
    send_frame(8'h01, pick_fc(), $urandom_range(MAX_FRAME - 3, MAX_FRAME), 1'b0);
    random_frames(15);
    settle();

    // Receiver holds off while short frames keep coming, so the block backs up.
    write_address(8'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (20) send_noise($urandom_range(2));
    random_frames(30);
    settle();

    if (tracker.mismatch_count == 0 && tracker.pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
